// File: rtl/wdbt_pkg.sv
// Package for the windowed dedupe bucket table: word types, bucket and FIFO entry
// layouts, function codes, state encoding and default sizes.
// Depends on nothing; the interfaces, the table RTL and the testbench use it.
package wdbt_pkg;

  localparam int BUCKETS_DEF     = 16;
  localparam int READY_DEPTH_DEF = 8;
  localparam logic [31:0] WINDOW_RESET = 32'd5000;
  localparam logic [3:0]  SLOT_LIMIT   = 4'd8;
  localparam logic [31:0] ORDER_FIRST  = 32'd1;

  typedef enum logic [1:0] {
    FN_INGEST = 2'd0,
    FN_TICK   = 2'd1,
    FN_POP    = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_FETCH,
    ST_ACT,
    ST_POP,
    ST_POP_D,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]        func;
    logic [63:0]       key;
    logic signed [7:0] rssi;
    logic [3:0]        scan_slot;
    logic [7:0]        slots_seen;
    logic              stamp_valid;
    logic [47:0]       epoch_ms;
    logic [31:0]       detail_tag;
    logic [47:0]       now_ms;
  } in_word_t;

  typedef struct packed {
    logic              accepted;
    logic              backpressure;
    logic [4:0]        moved_count;
    logic              upload_valid;
    logic signed [7:0] up_rssi;
    logic [7:0]        up_slots;
    logic              up_time_valid;
    logic [47:0]       up_epoch_ms;
    logic [31:0]       up_detail_tag;
  } out_word_t;

  typedef struct packed {
    logic [31:0] tag;
    logic        tv;
    logic [7:0]  slots;
    logic [7:0]  rssi;
  } misc_t;

  typedef struct packed {
    logic [63:0] key;
    logic [47:0] opened;
    logic [31:0] order;
    logic [47:0] epoch;
    misc_t       misc;
  } bucket_t;

  typedef struct packed {
    logic [47:0] epoch;
    misc_t       misc;
  } ready_t;

endpackage

// File: rtl/wdbt_if.sv
// Valid/ready channel interfaces for the input and result words of the table.
// Depends on wdbt_pkg for the payload types.
interface wdbt_in_if;
  logic               valid;
  logic               ready;
  wdbt_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface wdbt_out_if;
  logic                valid;
  logic                ready;
  wdbt_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/wdbt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module wdbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/windowed_dedupe_bucket_table.sv
// Windowed dedupe bucket table. One command word enters on in_ch and exactly one
// result word leaves on out_ch for it. func selects ingest, tick or pop.
// The user must write the window length through cfg_we/cfg_wdata only while the
// block is idle; the block itself does not enforce this. Bucket contents live in a
// BUCKETS-deep RAM and the ready FIFO in a READY_DEPTH-deep RAM; the used flags
// are flip-flops. Throughput is one command at a time. An ingest scans every
// bucket, then opens a free bucket, is refused, merges into the matching bucket or
// flushes a bucket to the FIFO and reopens a slot. A tick scans, flushes the oldest
// expired bucket and scans again until a scan finds none or the FIFO is full. A pop
// reads the FIFO head; an empty pop, a zero-key ingest or an unused function code
// goes straight to the result. Each scan visits the buckets in turn: the bucket RAM
// has one read port and returns one entry per cycle. The next word can be accepted
// in the cycle after the result has been loaded into the output register. Reset
// clears the used flags and the FIFO pointers and sets the order counter to its
// first value at once; no clearing pass is needed. When the receiver stalls, the
// finished result is held in the output register; the next command is still
// accepted, and its result waits until the held result is taken.
// Depends on wdbt_pkg, wdbt_if and wdbt_ram.
module windowed_dedupe_bucket_table #(
  parameter int BUCKETS     = wdbt_pkg::BUCKETS_DEF,
  parameter int READY_DEPTH = wdbt_pkg::READY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  wdbt_in_if.sink     in_ch,
  wdbt_out_if.source  out_ch
);

  localparam int IW = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
  localparam int CW = $clog2(BUCKETS + 1);
  localparam int HW = READY_DEPTH > 1 ? $clog2(READY_DEPTH) : 1;
  localparam int FW = $clog2(READY_DEPTH + 1);
  localparam int SW = FW + 1;

  wdbt_pkg::state_t   state, state_next;
  wdbt_pkg::in_word_t req;
  logic [7:0]         mask;
  logic [31:0]        window;

  logic [BUCKETS-1:0] used;
  logic [HW-1:0]      head;
  logic [FW-1:0]      fill;
  logic [31:0]        next_order;

  logic [CW-1:0] cnt;
  logic          dv;
  logic [IW-1:0] didx;
  logic          m_found, m_exp, f_found, o_found;
  logic [IW-1:0] m_idx, f_idx, o_idx;
  logic [31:0]   o_order;
  logic [IW-1:0] tgt_idx, open_idx;
  logic          op_merge;
  logic [4:0]    moved;

  wdbt_pkg::out_word_t res;
  logic                out_valid;
  wdbt_pkg::out_word_t out_data;

  // Bucket and FIFO RAM ports.
  logic              bk_we;
  logic [IW-1:0]     bk_waddr, bk_raddr;
  wdbt_pkg::bucket_t bk_wdata, bk_rdata;
  logic              rq_we;
  logic [HW-1:0]     rq_waddr;
  wdbt_pkg::ready_t  rq_wdata, rq_rdata;

  wdbt_ram #(.WIDTH($bits(wdbt_pkg::bucket_t)), .DEPTH(BUCKETS)) u_bucket_ram (
    .clk(clk), .we(bk_we), .waddr(bk_waddr), .wdata(bk_wdata),
    .raddr(bk_raddr), .rdata(bk_rdata)
  );

  wdbt_ram #(.WIDTH($bits(wdbt_pkg::ready_t)), .DEPTH(READY_DEPTH)) u_ready_ram (
    .clk(clk), .we(rq_we), .waddr(rq_waddr), .wdata(rq_wdata),
    .raddr(head), .rdata(rq_rdata)
  );

  logic in_acc, out_free, full, is_ingest, is_tick;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid || out_ch.ready;
  assign full      = (fill == FW'(READY_DEPTH));
  assign is_ingest = (req.func == wdbt_pkg::FN_INGEST);
  assign is_tick   = (req.func == wdbt_pkg::FN_TICK);

  // Scan datapath on the entry returned by the RAM.
  logic        sc_used, sc_exp, sc_last;
  logic [47:0] sc_age;
  assign sc_used = used[didx];
  assign sc_age  = req.now_ms - bk_rdata.opened;
  assign sc_exp  = (req.now_ms >= bk_rdata.opened) && (sc_age >= {16'd0, window});
  assign sc_last = dv && (cnt == CW'(BUCKETS));

  // FIFO tail position.
  logic [SW-1:0] tail_sum;
  logic [HW-1:0] tail;
  assign tail_sum = SW'(head) + SW'(fill);
  assign tail = (tail_sum >= SW'(READY_DEPTH)) ? HW'(tail_sum - SW'(READY_DEPTH))
                                               : HW'(tail_sum);

  logic [31:0] order_inc, order_next;
  assign order_inc  = next_order + 32'd1;
  assign order_next = (order_inc == 32'd0) ? wdbt_pkg::ORDER_FIRST : order_inc;

  // New bucket built from the request.
  wdbt_pkg::bucket_t new_entry;
  always_comb begin
    new_entry.key        = req.key;
    new_entry.opened     = req.now_ms;
    new_entry.order      = next_order;
    new_entry.epoch      = req.epoch_ms;
    new_entry.misc.tag   = req.detail_tag;
    new_entry.misc.tv    = req.stamp_valid;
    new_entry.misc.slots = mask;
    new_entry.misc.rssi  = req.rssi;
  end

  // Merge of the request into the fetched bucket.
  wdbt_pkg::bucket_t merged;
  logic signed [7:0] have;
  logic              repl;
  always_comb begin
    have = $signed(bk_rdata.misc.rssi);
    repl = (req.rssi < 0) && ((have >= 0) || (req.rssi > have));
    merged = bk_rdata;
    merged.misc.slots = bk_rdata.misc.slots | mask;
    if (repl) begin
      merged.misc.rssi = req.rssi;
      merged.misc.tag  = req.detail_tag;
    end
    if (bk_rdata.misc.tv && req.stamp_valid) begin
      merged.misc.tv = 1'b1;
      merged.epoch   = (bk_rdata.epoch < req.epoch_ms) ? bk_rdata.epoch : req.epoch_ms;
    end else if (bk_rdata.misc.tv) begin
      merged.misc.tv = 1'b1;
      merged.epoch   = bk_rdata.epoch;
    end else if (req.stamp_valid) begin
      merged.misc.tv = 1'b1;
      merged.epoch   = req.epoch_ms;
    end else begin
      merged.misc.tv = 1'b0;
      merged.epoch   = 48'd0;
    end
  end

  logic direct_open;
  assign direct_open = (state == wdbt_pkg::ST_DECIDE) && is_ingest && !m_found && f_found;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      wdbt_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.data.func)
            wdbt_pkg::FN_INGEST:
              state_next = (in_ch.data.key == 64'd0) ? wdbt_pkg::ST_DONE : wdbt_pkg::ST_SCAN;
            wdbt_pkg::FN_TICK: state_next = wdbt_pkg::ST_SCAN;
            wdbt_pkg::FN_POP:
              state_next = (fill != '0) ? wdbt_pkg::ST_POP : wdbt_pkg::ST_DONE;
            default: state_next = wdbt_pkg::ST_DONE;
          endcase
        end
      end
      wdbt_pkg::ST_SCAN:
        if (sc_last) state_next = wdbt_pkg::ST_DECIDE;
      wdbt_pkg::ST_DECIDE: begin
        if (is_tick) begin
          state_next = (o_found && !full) ? wdbt_pkg::ST_FETCH : wdbt_pkg::ST_DONE;
        end else if (m_found && !m_exp) begin
          state_next = wdbt_pkg::ST_FETCH;
        end else if (f_found && !m_found) begin
          state_next = wdbt_pkg::ST_DONE;
        end else begin
          state_next = full ? wdbt_pkg::ST_DONE : wdbt_pkg::ST_FETCH;
        end
      end
      wdbt_pkg::ST_FETCH: state_next = wdbt_pkg::ST_ACT;
      wdbt_pkg::ST_ACT: begin
        if (is_tick && (SW'(fill) + SW'(1) < SW'(READY_DEPTH))) begin
          state_next = wdbt_pkg::ST_SCAN;
        end else begin
          state_next = wdbt_pkg::ST_DONE;
        end
      end
      wdbt_pkg::ST_POP:   state_next = wdbt_pkg::ST_POP_D;
      wdbt_pkg::ST_POP_D: state_next = wdbt_pkg::ST_DONE;
      wdbt_pkg::ST_DONE:
        if (out_free) state_next = wdbt_pkg::ST_IDLE;
      default: state_next = wdbt_pkg::ST_IDLE;
    endcase
  end

  // Memory ports and handshake outputs.
  always_comb begin
    in_ch.ready = (state == wdbt_pkg::ST_IDLE);
    bk_raddr    = (state == wdbt_pkg::ST_SCAN) ? cnt[IW-1:0] : tgt_idx;
    bk_we       = 1'b0;
    bk_waddr    = open_idx;
    bk_wdata    = new_entry;
    rq_we       = 1'b0;
    rq_waddr    = tail;
    rq_wdata.epoch = bk_rdata.epoch;
    rq_wdata.misc  = bk_rdata.misc;
    if (direct_open) begin
      bk_we    = 1'b1;
      bk_waddr = f_idx;
    end else if (state == wdbt_pkg::ST_ACT) begin
      if (op_merge) begin
        bk_we    = 1'b1;
        bk_waddr = tgt_idx;
        bk_wdata = merged;
      end else begin
        rq_we = 1'b1;
        bk_we = is_ingest;
      end
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= wdbt_pkg::ST_IDLE;
      window     <= wdbt_pkg::WINDOW_RESET;
      used       <= '0;
      head       <= '0;
      fill       <= '0;
      next_order <= wdbt_pkg::ORDER_FIRST;
      out_valid  <= 1'b0;
      dv         <= 1'b0;
      cnt        <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        window <= cfg_wdata;
      end
      if (state == wdbt_pkg::ST_DONE && out_free) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        wdbt_pkg::ST_IDLE: begin
          if (in_acc) begin
            req <= in_ch.data;
            if (in_ch.data.slots_seen == 8'd0 && in_ch.data.scan_slot < wdbt_pkg::SLOT_LIMIT)
            begin
              mask <= 8'd1 << in_ch.data.scan_slot[2:0];
            end else begin
              mask <= in_ch.data.slots_seen;
            end
            res     <= '0;
            moved   <= '0;
            cnt     <= '0;
            dv      <= 1'b0;
            m_found <= 1'b0;
            f_found <= 1'b0;
            o_found <= 1'b0;
          end
        end
        wdbt_pkg::ST_SCAN: begin
          if (cnt < CW'(BUCKETS)) begin
            cnt  <= cnt + CW'(1);
            dv   <= 1'b1;
            didx <= cnt[IW-1:0];
          end else begin
            dv <= 1'b0;
          end
          if (dv) begin
            if (sc_used && bk_rdata.key == req.key && !m_found) begin
              m_found <= 1'b1;
              m_idx   <= didx;
              m_exp   <= sc_exp;
            end
            if (!sc_used && !f_found) begin
              f_found <= 1'b1;
              f_idx   <= didx;
            end
            if (sc_used && (is_ingest || sc_exp) && (!o_found || bk_rdata.order < o_order))
            begin
              o_found <= 1'b1;
              o_idx   <= didx;
              o_order <= bk_rdata.order;
            end
          end
        end
        wdbt_pkg::ST_DECIDE: begin
          if (is_tick) begin
            res.moved_count <= moved;
            tgt_idx  <= o_idx;
            op_merge <= 1'b0;
          end else if (m_found && !m_exp) begin
            tgt_idx  <= m_idx;
            op_merge <= 1'b1;
          end else if (m_found) begin
            tgt_idx  <= m_idx;
            open_idx <= (f_found && f_idx < m_idx) ? f_idx : m_idx;
            op_merge <= 1'b0;
            res.backpressure <= full;
          end else if (f_found) begin
            used[f_idx]  <= 1'b1;
            next_order   <= order_next;
            res.accepted <= 1'b1;
          end else begin
            tgt_idx  <= o_idx;
            open_idx <= o_idx;
            op_merge <= 1'b0;
            res.backpressure <= full;
          end
        end
        wdbt_pkg::ST_ACT: begin
          cnt     <= '0;
          dv      <= 1'b0;
          o_found <= 1'b0;
          if (op_merge) begin
            res.accepted <= 1'b1;
          end else begin
            fill <= fill + FW'(1);
            // The flushed bucket is freed; an ingest reopens the lowest free slot at once.
            used <= (used & ~(BUCKETS'(1) << tgt_idx))
                    | (is_ingest ? (BUCKETS'(1) << open_idx) : '0);
            if (is_ingest) begin
              next_order     <= order_next;
              res.accepted   <= 1'b1;
            end else begin
              moved           <= (moved == 5'd31) ? moved : moved + 5'd1;
              res.moved_count <= (moved == 5'd31) ? moved : moved + 5'd1;
            end
          end
        end
        wdbt_pkg::ST_POP_D: begin
          res.upload_valid  <= 1'b1;
          res.up_rssi       <= rq_rdata.misc.rssi;
          res.up_slots      <= rq_rdata.misc.slots;
          res.up_time_valid <= rq_rdata.misc.tv;
          res.up_epoch_ms   <= rq_rdata.epoch;
          res.up_detail_tag <= rq_rdata.misc.tag;
          head <= (head == HW'(READY_DEPTH - 1)) ? '0 : head + HW'(1);
          fill <= fill - FW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // The FIFO never holds more entries than it has places.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(READY_DEPTH))
    else $error("ready FIFO fill above its depth");

  // The order counter skips zero when it wraps.
  a_order_nonzero: assert property (@(posedge clk) disable iff (rst)
    next_order != 32'd0)
    else $error("insertion order counter reached zero");

  // A result word reports at most one kind of outcome.
  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({out_data.accepted, out_data.backpressure,
                              out_data.upload_valid, out_data.moved_count != 5'd0}) <= 1)
    else $error("result word reports more than one outcome");

  // A flush always has room in the FIFO.
  a_flush_room: assert property (@(posedge clk) disable iff (rst)
    (state == wdbt_pkg::ST_ACT && !op_merge) |-> !full)
    else $error("flush into a full ready FIFO");

endmodule

// File: tb/sv/wdbt_tb_pkg.sv
// Scoreboard class for the windowed dedupe bucket table testbench.
// Holds a bit-accurate predictor of the table and a queue of expected result words.
// Depends on wdbt_pkg.
package wdbt_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB = wdbt_pkg::BUCKETS_DEF;
  localparam int NR = wdbt_pkg::READY_DEPTH_DEF;

  class table_scoreboard;
    logic [31:0]         window;
    bit                  used [NB];
    logic [63:0]         bkey [NB];
    logic [47:0]         opened [NB];
    logic [31:0]         order [NB];
    logic [47:0]         bepoch [NB];
    wdbt_pkg::misc_t     bmisc [NB];
    logic [47:0]         repoch [NR];
    wdbt_pkg::misc_t     rmisc [NR];
    int unsigned         head;
    int unsigned         fill;
    logic [31:0]         next_order;
    wdbt_pkg::out_word_t pending [$];
    int                  errors;

    function new();
      window = wdbt_pkg::WINDOW_RESET;
      foreach (used[i]) used[i] = 1'b0;
      head = 0;
      fill = 0;
      next_order = wdbt_pkg::ORDER_FIRST;
      errors = 0;
    endfunction

    function bit expired(int i, logic [47:0] now);
      return used[i] && now >= opened[i] && (now - opened[i]) >= {16'd0, window};
    endfunction

    function int oldest(logic [47:0] now, bit only_expired);
      int best;
      best = -1;
      for (int i = 0; i < NB; i++) begin
        if (!used[i]) continue;
        if (only_expired && !expired(i, now)) continue;
        if (best < 0 || order[i] < order[best]) best = i;
      end
      return best;
    endfunction

    function int first_free();
      for (int i = 0; i < NB; i++) if (!used[i]) return i;
      return -1;
    endfunction

    function bit flush(int i);
      int unsigned tail;
      if (i < 0 || !used[i] || fill >= NR) return 1'b0;
      tail = (head + fill) % NR;
      repoch[tail] = bepoch[i];
      rmisc[tail] = bmisc[i];
      fill++;
      used[i] = 1'b0;
      return 1'b1;
    endfunction

    function void ingest(wdbt_pkg::in_word_t w, ref wdbt_pkg::out_word_t r);
      logic [7:0] mask;
      int m;
      wdbt_pkg::misc_t cur;
      if (w.key == 64'd0) return;
      mask = w.slots_seen;
      if (mask == 8'd0 && w.scan_slot < wdbt_pkg::SLOT_LIMIT) mask = 8'd1 << w.scan_slot;
      m = -1;
      for (int i = 0; i < NB; i++)
        if (used[i] && bkey[i] == w.key) begin
          m = i;
          break;
        end
      if (m >= 0 && expired(m, w.now_ms)) begin
        if (!flush(m)) begin
          r.backpressure = 1'b1;
          return;
        end
        m = -1;
      end
      if (m >= 0) begin
        cur = bmisc[m];
        cur.slots |= mask;
        if (w.rssi < 0 && ($signed(cur.rssi) >= 0 || w.rssi > $signed(cur.rssi))) begin
          cur.rssi = w.rssi;
          cur.tag = w.detail_tag;
        end
        if (cur.tv && w.stamp_valid) begin
          if (w.epoch_ms < bepoch[m]) bepoch[m] = w.epoch_ms;
        end else if (w.stamp_valid) begin
          cur.tv = 1'b1;
          bepoch[m] = w.epoch_ms;
        end else if (!cur.tv) begin
          bepoch[m] = 48'd0;
        end
        bmisc[m] = cur;
        r.accepted = 1'b1;
        return;
      end
      m = first_free();
      if (m < 0) begin
        if (!flush(oldest(w.now_ms, 1'b0))) begin
          r.backpressure = 1'b1;
          return;
        end
        m = first_free();
      end
      used[m] = 1'b1;
      bkey[m] = w.key;
      opened[m] = w.now_ms;
      order[m] = next_order;
      next_order++;
      if (next_order == 32'd0) next_order = wdbt_pkg::ORDER_FIRST;
      bepoch[m] = w.epoch_ms;
      bmisc[m] = '{tag: w.detail_tag, tv: w.stamp_valid, slots: mask, rssi: w.rssi};
      r.accepted = 1'b1;
    endfunction

    function void note_command(wdbt_pkg::in_word_t w);
      wdbt_pkg::out_word_t r;
      int moved;
      r = '0;
      case (wdbt_pkg::func_t'(w.func))
        wdbt_pkg::FN_INGEST: ingest(w, r);
        wdbt_pkg::FN_TICK: begin
          moved = 0;
          while (fill < NR && flush(oldest(w.now_ms, 1'b1))) moved++;
          r.moved_count = moved > 31 ? 5'd31 : 5'(moved);
        end
        wdbt_pkg::FN_POP: begin
          if (fill > 0) begin
            r.upload_valid = 1'b1;
            r.up_rssi = rmisc[head].rssi;
            r.up_slots = rmisc[head].slots;
            r.up_time_valid = rmisc[head].tv;
            r.up_epoch_ms = repoch[head];
            r.up_detail_tag = rmisc[head].tag;
            head = (head + 1) % NR;
            fill--;
          end
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(wdbt_pkg::out_word_t got);
      wdbt_pkg::out_word_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word %h", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.accepted !== want.accepted) report("accepted", want.accepted, got.accepted);
      if (got.backpressure !== want.backpressure)
        report("backpressure", want.backpressure, got.backpressure);
      if (got.moved_count !== want.moved_count)
        report("moved_count", want.moved_count, got.moved_count);
      if (got.upload_valid !== want.upload_valid)
        report("upload_valid", want.upload_valid, got.upload_valid);
      if (got.up_rssi !== want.up_rssi) report("up_rssi", want.up_rssi, got.up_rssi);
      if (got.up_slots !== want.up_slots) report("up_slots", want.up_slots, got.up_slots);
      if (got.up_time_valid !== want.up_time_valid)
        report("up_time_valid", want.up_time_valid, got.up_time_valid);
      if (got.up_epoch_ms !== want.up_epoch_ms)
        report("up_epoch_ms", want.up_epoch_ms, got.up_epoch_ms);
      if (got.up_detail_tag !== want.up_detail_tag)
        report("up_detail_tag", want.up_detail_tag, got.up_detail_tag);
    endfunction

    function void report(string field, logic [63:0] want, logic [63:0] got);
      $display("%0t: %s expected %h actual %h", $realtime, field, want, got);
      errors++;
    endfunction
  endclass
endpackage

// File: tb/sv/tb_top.sv
// Top of the windowed dedupe bucket table testbench: clock, reset, drivers for the
// command and result channels, window register writes and the final verdict.
// Depends on wdbt_pkg, wdbt_if, wdbt_tb_pkg and the table RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [31:0] cfg_wdata = '0;
  int          send_idle = 0;
  int          recv_idle = 0;
  logic [63:0] keys [6];
  logic [47:0] clock_ms = 0;
  wdbt_tb_pkg::table_scoreboard sb = new();

  wdbt_in_if  in_ch();
  wdbt_out_if out_ch();

  windowed_dedupe_bucket_table DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #10 clk = ~clk;

  // The receiver stalls at random; every accepted word is checked at the edge.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    out_ch.ready <= !rst && ($urandom_range(99) >= recv_idle);
  end

  // The word is held until accepted; valid stays high into the next send so that
  // back-to-back words see no gap.
  task automatic send(wdbt_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_command(w);
  endtask

  task automatic set_window(logic [31:0] value);
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 0;
    sb.window = value;
  endtask

  function automatic wdbt_pkg::in_word_t make_word(logic [1:0] fn, logic [63:0] key);
    wdbt_pkg::in_word_t w;
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    w = raw[$bits(wdbt_pkg::in_word_t)-1:0];
    w.func = fn;
    w.key = key;
    w.now_ms = clock_ms;
    if ($urandom_range(3) == 0) w.slots_seen = 8'd0;
    return w;
  endfunction

  task automatic random_phase(int count, int s_idle, int r_idle);
    wdbt_pkg::in_word_t w;
    int pick;
    send_idle = s_idle;
    recv_idle = r_idle;
    for (int n = 0; n < count; n++) begin
      clock_ms += $urandom_range(400);
      if ($urandom_range(200) == 0) clock_ms -= $urandom_range(2000);
      pick = $urandom_range(99);
      if (pick < 55)
        w = make_word(wdbt_pkg::FN_INGEST, $urandom_range(9) == 0 ? {$urandom, $urandom}
                                                                 : keys[$urandom_range(5)]);
      else if (pick < 70) w = make_word(wdbt_pkg::FN_TICK, 64'd0);
      else if (pick < 97) w = make_word(wdbt_pkg::FN_POP, 64'd0);
      else if (pick < 99) w = make_word(wdbt_pkg::FN_INGEST, 64'd0);
      else w = make_word(wdbt_pkg::FN_NONE, 64'd0);
      if ($urandom_range(40) == 0) w.now_ms = 48'({$urandom, $urandom});
      send(w);
    end
  endtask

  initial begin
    wdbt_pkg::in_word_t w;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    foreach (keys[i]) keys[i] = {$urandom, $urandom};
    keys[0] = '1;
    keys[1] = 64'd1;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: zero key, unused code, empty pop, merges, eviction, ticks and pops.
    send(make_word(wdbt_pkg::FN_INGEST, 64'd0));
    send(make_word(wdbt_pkg::FN_NONE, 64'd0));
    send(make_word(wdbt_pkg::FN_POP, 64'd0));
    w = make_word(wdbt_pkg::FN_INGEST, keys[0]);
    w.rssi = 8'sh80; w.stamp_valid = 1'b0; w.slots_seen = 8'd0; w.scan_slot = 4'd15;
    w.epoch_ms = '1;
    send(w);
    w.rssi = 8'sh7F; w.stamp_valid = 1'b0; w.scan_slot = 4'd7;
    send(w);
    w.rssi = 8'shFF; w.stamp_valid = 1'b1; w.epoch_ms = '0;
    send(w);
    w.rssi = 8'sh00; w.epoch_ms = '1; w.slots_seen = 8'hFF;
    send(w);
    for (int i = 0; i < 18; i++) send(make_word(wdbt_pkg::FN_INGEST, 64'(i + 2)));
    clock_ms = 48'hFFFF_FFFF_FFFF;
    send(make_word(wdbt_pkg::FN_TICK, 64'd0));
    for (int i = 0; i < 9; i++) send(make_word(wdbt_pkg::FN_POP, 64'd0));
    set_window(32'd0);
    clock_ms = 0;
    for (int i = 0; i < 3; i++) send(make_word(wdbt_pkg::FN_INGEST, keys[0]));
    send(make_word(wdbt_pkg::FN_TICK, 64'd0));

    set_window(32'd300);
    random_phase(330, 28, 49);
    set_window(32'hFFFF_FFFF);
    random_phase(330, 49, 28);
    set_window(32'd1);
    random_phase(170, 0, 0);
    set_window(wdbt_pkg::WINDOW_RESET);
    random_phase(170, 0, 0);

    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
